### hdl/display_sleep_window_scheduler_unit_defines.svh
// Assertion macros for the display sleep window scheduler.
// Included by the RTL files that carry assertions; depends on nothing else.
`ifndef DISPLAY_SLEEP_WINDOW_SCHEDULER_UNIT_DEFINES_SVH
`define DISPLAY_SLEEP_WINDOW_SCHEDULER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising edge of i_clk outside reset.
`define DSWS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, sampled on the rising edge of i_clk outside reset.
`define DSWS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define DSWS_ASSERT_IMPLY(lbl, ante, cons)
`define DSWS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/dsws_pkg.sv
// Shared types and constants for the display sleep window scheduler.
// Used by dsws_decide and the top level; depends on nothing.
`default_nettype none

package dsws_pkg;

    localparam int MIN_PER_HOUR = 60;
    localparam int MOD_W        = 11;   // 31*60+63 fits in 11 bits

    // Commands carried by an item.
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_PREVIEW = 1'b1;

    // Configuration register indexes.
    localparam int          CFG_IDX_W          = 3;
    localparam int          CFG_DATA_W         = 8;
    localparam logic [2:0]  REG_SLEEP_ENABLE   = 3'd0;
    localparam logic [2:0]  REG_START_HOUR     = 3'd1;
    localparam logic [2:0]  REG_START_MINUTE   = 3'd2;
    localparam logic [2:0]  REG_END_HOUR       = 3'd3;
    localparam logic [2:0]  REG_END_MINUTE     = 3'd4;
    localparam logic [2:0]  REG_SCREEN_AWAKE   = 3'd5;
    localparam logic [2:0]  REG_LED_AWAKE      = 3'd6;

    typedef struct packed {
        logic       sleep_enable;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [4:0] end_hour;
        logic [5:0] end_minute;
        logic [7:0] screen_level_awake;
        logic [7:0] led_level_awake;
    } t_cfg;

    typedef struct packed {
        logic        sleeping;
        logic        preview_active;
        logic [31:0] preview_deadline;
    } t_state;

    typedef struct packed {
        logic        command;
        logic [31:0] now_ms;
        logic [4:0]  clock_hour;
        logic [5:0]  clock_minute;
        logic        clock_valid;
        logic [31:0] preview_ms;
    } t_item;

    typedef struct packed {
        logic       screen_write;
        logic [7:0] screen_level;
        logic       led_write;
        logic [7:0] led_level;
        logic       asleep;
        logic       preview_on;
    } t_result;

    // Minute of day, formed exactly without clamping.
    function automatic logic [MOD_W-1:0] minute_of_day(input logic [4:0] hour,
                                                       input logic [5:0] minute);
        minute_of_day = MOD_W'(hour) * MOD_W'(MIN_PER_HOUR) + MOD_W'(minute);
    endfunction

endpackage

`default_nettype wire

### hdl/display_sleep_window_scheduler_unit.sv
// Top level of the display sleep window scheduler: ports, registers, configuration.
// Depends on dsws_pkg, dsws_decide and display_sleep_window_scheduler_unit_defines.svh.
//
// Each item is either an update tick or a preview request and yields exactly one
// result item. An item is first captured in an input register; in the following
// cycle the decision logic works on it together with the sleep state left by the
// item before it, and the result register and the state registers load together.
// One item is taken in every cycle as long as the downstream side keeps taking
// results; a stall on the output holds the result register, and the input stall
// rises only once both registers are occupied, so a new item is still accepted
// while a finished result waits. Configuration writes are always accepted (ready
// is always high) and are meant to happen only while no item is in flight; an
// unknown register index is ignored.
`default_nettype none
`include "display_sleep_window_scheduler_unit_defines.svh"

module display_sleep_window_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Item input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [31:0] i_now_ms,
    input  logic [4:0]  i_clock_hour,
    input  logic [5:0]  i_clock_minute,
    input  logic        i_clock_valid,
    input  logic [31:0] i_preview_ms,

    // Result output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_screen_write,
    output logic [7:0]  o_screen_level,
    output logic        o_led_write,
    output logic [7:0]  o_led_level,
    output logic        o_asleep,
    output logic        o_preview_on,

    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dsws_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dsws_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dsws_pkg::t_cfg    r_cfg;
    dsws_pkg::t_state  r_state;
    dsws_pkg::t_state  n_state;
    dsws_pkg::t_item   r_item;
    dsws_pkg::t_result r_res;
    dsws_pkg::t_result n_res;
    logic              r_item_vld;
    logic              r_res_vld;
    logic              advance;
    logic              in_take;

    // The result register may load when it is empty or its item is being taken.
    assign advance = !r_res_vld || !i_stall;
    // The input register can take a new item unless it holds one that cannot move on.
    assign o_stall = r_item_vld && !advance;
    assign in_take = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    // Configuration registers, reset to the documented defaults.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sleep_enable       <= 1'b0;
            r_cfg.start_hour         <= 5'd22;
            r_cfg.start_minute       <= 6'd0;
            r_cfg.end_hour           <= 5'd7;
            r_cfg.end_minute         <= 6'd0;
            r_cfg.screen_level_awake <= 8'd200;
            r_cfg.led_level_awake    <= 8'd120;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dsws_pkg::REG_SLEEP_ENABLE: r_cfg.sleep_enable       <= i_cfg_data[0];
                dsws_pkg::REG_START_HOUR:   r_cfg.start_hour         <= i_cfg_data[4:0];
                dsws_pkg::REG_START_MINUTE: r_cfg.start_minute       <= i_cfg_data[5:0];
                dsws_pkg::REG_END_HOUR:     r_cfg.end_hour           <= i_cfg_data[4:0];
                dsws_pkg::REG_END_MINUTE:   r_cfg.end_minute         <= i_cfg_data[5:0];
                dsws_pkg::REG_SCREEN_AWAKE: r_cfg.screen_level_awake <= i_cfg_data;
                dsws_pkg::REG_LED_AWAKE:    r_cfg.led_level_awake    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: payload held without reset, valid flag under reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.command      <= i_command;
            r_item.now_ms       <= i_now_ms;
            r_item.clock_hour   <= i_clock_hour;
            r_item.clock_minute <= i_clock_minute;
            r_item.clock_valid  <= i_clock_valid;
            r_item.preview_ms   <= i_preview_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
        end else if (!o_stall) begin
            r_item_vld <= i_valid;
        end
    end

    dsws_decide u_decide (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // Sleep state moves on only when the item in the input register is retired.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance && r_item_vld) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (advance) begin
            r_res_vld <= r_item_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_item_vld) begin
            r_res <= n_res;
        end
    end

    assign o_valid        = r_res_vld;
    assign o_screen_write = r_res.screen_write;
    assign o_screen_level = r_res.screen_level;
    assign o_led_write    = r_res.led_write;
    assign o_led_level    = r_res.led_level;
    assign o_asleep       = r_res.asleep;
    assign o_preview_on   = r_res.preview_on;

    // A preview can only be running while the display sleeps.
    `DSWS_ASSERT_IMPLY(a_preview_needs_sleep, r_state.preview_active, r_state.sleeping)
    // Every LED write comes with a screen write in the same result.
    `DSWS_ASSERT_IMPLY(a_led_with_screen, o_valid && o_led_write, o_screen_write)
    // Without a screen write the reported level is zero.
    `DSWS_ASSERT_IMPLY(a_no_write_zero, o_valid && !o_screen_write, o_screen_level == 8'd0)
    // The input stall only rises when a result is waiting.
    `DSWS_ASSERT_IMPLY(a_stall_needs_result, o_stall, o_valid && r_item_vld)
    // An item that leaves the input register shows up as a result next cycle.
    `DSWS_ASSERT_NEXT(a_item_reaches_output, r_item_vld && advance, o_valid)

endmodule

`default_nettype wire

### hdl/dsws_decide.sv
// Decision logic for one item: preview expiry, window test, sleep entry and exit.
// Purely combinational; depends on dsws_pkg.
`default_nettype none

module dsws_decide (
    input  dsws_pkg::t_cfg    i_cfg,
    input  dsws_pkg::t_state  i_state,
    input  dsws_pkg::t_item   i_item,
    output dsws_pkg::t_state  o_state,
    output dsws_pkg::t_result o_result
);

    logic [31:0]               since_deadline;
    logic                      expired;
    logic [dsws_pkg::MOD_W-1:0] now_mod;
    logic [dsws_pkg::MOD_W-1:0] start_mod;
    logic [dsws_pkg::MOD_W-1:0] end_mod;
    logic                      want_sleep;

    assign since_deadline = i_item.now_ms - i_state.preview_deadline;
    assign expired        = ~since_deadline[31];

    assign now_mod   = dsws_pkg::minute_of_day(i_item.clock_hour, i_item.clock_minute);
    assign start_mod = dsws_pkg::minute_of_day(i_cfg.start_hour, i_cfg.start_minute);
    assign end_mod   = dsws_pkg::minute_of_day(i_cfg.end_hour, i_cfg.end_minute);

    // A window whose start lies after its end wraps past midnight.
    assign want_sleep = (start_mod > end_mod) ? ((now_mod >= start_mod) || (now_mod < end_mod))
                                              : ((now_mod >= start_mod) && (now_mod < end_mod));

    always_comb begin
        o_state  = i_state;
        o_result = '0;

        if (i_item.command == dsws_pkg::CMD_PREVIEW) begin
            if (i_cfg.sleep_enable && i_state.sleeping) begin
                o_state.preview_active   = 1'b1;
                o_state.preview_deadline = i_item.now_ms + i_item.preview_ms;
                o_result.screen_write    = 1'b1;
                o_result.screen_level    = i_cfg.screen_level_awake;
            end
        end else begin
            if (i_state.sleeping && i_state.preview_active && expired) begin
                o_state.preview_active = 1'b0;
                o_result.screen_write  = 1'b1;
                o_result.screen_level  = 8'd0;
            end
            if (!i_cfg.sleep_enable) begin
                if (i_state.sleeping) begin
                    o_state.sleeping       = 1'b0;
                    o_state.preview_active = 1'b0;
                    o_result.screen_write  = 1'b1;
                    o_result.screen_level  = i_cfg.screen_level_awake;
                    o_result.led_write     = 1'b1;
                    o_result.led_level     = i_cfg.led_level_awake;
                end
            end else if (i_item.clock_valid) begin
                if (want_sleep && !i_state.sleeping) begin
                    o_state.sleeping       = 1'b1;
                    o_state.preview_active = 1'b0;
                    o_result.screen_write  = 1'b1;
                    o_result.screen_level  = 8'd0;
                    o_result.led_write     = 1'b1;
                    o_result.led_level     = 8'd0;
                end else if (!want_sleep && i_state.sleeping) begin
                    o_state.sleeping       = 1'b0;
                    o_state.preview_active = 1'b0;
                    o_result.screen_write  = 1'b1;
                    o_result.screen_level  = i_cfg.screen_level_awake;
                    o_result.led_write     = 1'b1;
                    o_result.led_level     = i_cfg.led_level_awake;
                end
            end
        end

        o_result.asleep     = o_state.sleeping;
        o_result.preview_on = o_state.preview_active;
    end

endmodule

`default_nettype wire

### test/display_sleep_window_scheduler_unit_tb.sv
// Self-checking testbench for display_sleep_window_scheduler_unit.
// Depends on dsws_pkg and the RTL; a built-in predictor checks every result item.
`default_nettype none

module display_sleep_window_scheduler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD  = 2;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          LONG_HOLD   = 80;
    localparam int          PHASE_ITEMS = 265;
    localparam int          NUM_PHASES  = 6;
    localparam int          DRAIN_WAIT  = 6;
    // Index 7 is not a register; writes to it must be ignored.
    localparam logic [2:0]  REG_UNUSED  = 3'd7;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic        i_stall   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;
    logic        hold_start = 1'b0;
    dsws_pkg::t_item bus_item = '0;

    logic        o_stall;
    logic        o_valid;
    logic        o_screen_write;
    logic [7:0]  o_screen_level;
    logic        o_led_write;
    logic [7:0]  o_led_level;
    logic        o_asleep;
    logic        o_preview_on;
    logic        o_cfg_ready;

    // Items waiting to be offered, and result items predicted but not yet seen.
    dsws_pkg::t_item   stim_queue[$];
    dsws_pkg::t_result awaited_results[$];

    // Predictor copy of the registers and of the sleep state.
    dsws_pkg::t_cfg regs_model;
    logic        asleep_model   = 1'b0;
    logic        preview_model  = 1'b0;
    logic [31:0] deadline_model = '0;

    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int unsigned hold_left    = 0;
    int unsigned cycles       = 0;
    int          errors       = 0;
    int          items_taken  = 0;
    int          n_sleeps     = 0;
    int          n_wakes      = 0;
    int          n_previews   = 0;
    int          n_expiries   = 0;

    // Stimulus generator state: a millisecond clock and a wall clock that drift forward.
    logic [31:0] ms_now      = 32'd1000;
    int unsigned wall_minute = 0;

    display_sleep_window_scheduler_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (bus_item.command),
        .i_now_ms       (bus_item.now_ms),
        .i_clock_hour   (bus_item.clock_hour),
        .i_clock_minute (bus_item.clock_minute),
        .i_clock_valid  (bus_item.clock_valid),
        .i_preview_ms   (bus_item.preview_ms),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_screen_write (o_screen_write),
        .o_screen_level (o_screen_level),
        .o_led_write    (o_led_write),
        .o_led_level    (o_led_level),
        .o_asleep       (o_asleep),
        .o_preview_on   (o_preview_on),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Works out the result item of one accepted item and advances the predicted state.
    function automatic dsws_pkg::t_result schedule_step(input dsws_pkg::t_item it);
        dsws_pkg::t_result r;
        logic [31:0] lag;
        int unsigned now_mod, start_mod, end_mod;
        logic        want_sleep;
        r = '0;
        if (it.command == dsws_pkg::CMD_PREVIEW) begin
            // A preview is only honoured while the window is enabled and the display sleeps.
            if (regs_model.sleep_enable && asleep_model) begin
                preview_model  = 1'b1;
                deadline_model = it.now_ms + it.preview_ms;
                r.screen_write = 1'b1;
                r.screen_level = regs_model.screen_level_awake;
                n_previews++;
            end
        end else begin
            // The deadline has passed when the wrapped difference is not negative.
            lag = it.now_ms - deadline_model;
            if (asleep_model && preview_model && !lag[31]) begin
                r.screen_write = 1'b1;
                r.screen_level = 8'd0;
                preview_model  = 1'b0;
                n_expiries++;
            end
            want_sleep = 1'b0;
            if (regs_model.sleep_enable && it.clock_valid) begin
                now_mod   = it.clock_hour * dsws_pkg::MIN_PER_HOUR + it.clock_minute;
                start_mod = regs_model.start_hour * dsws_pkg::MIN_PER_HOUR
                            + regs_model.start_minute;
                end_mod   = regs_model.end_hour * dsws_pkg::MIN_PER_HOUR
                            + regs_model.end_minute;
                // A window whose start lies after its end wraps past midnight.
                if (start_mod > end_mod) begin
                    want_sleep = (now_mod >= start_mod) || (now_mod < end_mod);
                end else begin
                    want_sleep = (now_mod >= start_mod) && (now_mod < end_mod);
                end
            end
            if (regs_model.sleep_enable && it.clock_valid && want_sleep && !asleep_model) begin
                asleep_model   = 1'b1;
                preview_model  = 1'b0;
                r.screen_write = 1'b1;
                r.screen_level = 8'd0;
                r.led_write    = 1'b1;
                r.led_level    = 8'd0;
                n_sleeps++;
            end else if (asleep_model && (!regs_model.sleep_enable ||
                                          (it.clock_valid && !want_sleep))) begin
                // Waking after an expiry in the same tick leaves the awake level on screen.
                asleep_model   = 1'b0;
                preview_model  = 1'b0;
                r.screen_write = 1'b1;
                r.screen_level = regs_model.screen_level_awake;
                r.led_write    = 1'b1;
                r.led_level    = regs_model.led_level_awake;
                n_wakes++;
            end
        end
        r.asleep     = asleep_model;
        r.preview_on = preview_model;
        return r;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Driver: offers items from the queue, holds a stalled item, and idles at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                awaited_results.push_back(schedule_step(bus_item));
                items_taken++;
            end
            if (!(i_valid && o_stall)) begin
                if (stim_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    bus_item <= stim_queue.pop_front();
                    i_valid  <= 1'b1;
                end else begin
                    i_valid  <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result item against the oldest prediction.
    always @(posedge i_clk) begin
        dsws_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: result item with no prediction waiting", $time);
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("screen_write", want.screen_write, o_screen_write);
                    compare_field("screen_level", want.screen_level, o_screen_level);
                    compare_field("led_write", want.led_write, o_led_write);
                    compare_field("led_level", want.led_level, o_led_level);
                    compare_field("asleep", want.asleep, o_asleep);
                    compare_field("preview_on", want.preview_on, o_preview_on);
                end
            end
            i_stall <= (hold_left != 0) || ($urandom_range(99) < snk_idle_pct);
        end
    end

    // Long receiver hold-off, counted here so that the sender keeps offering items.
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d predictions outstanding",
                     cycles, awaited_results.size());
            $display("FAIL display_sleep_window_scheduler_unit");
            $finish;
        end
    end

    task automatic queue_item(input logic cmd, input logic [31:0] ms, input logic [4:0] hour,
                              input logic [5:0] minute, input logic clk_ok,
                              input logic [31:0] span);
        dsws_pkg::t_item it;
        it.command      = cmd;
        it.now_ms       = ms;
        it.clock_hour   = hour;
        it.clock_minute = minute;
        it.clock_valid  = clk_ok;
        it.preview_ms   = span;
        stim_queue.push_back(it);
    endtask

    // Mostly a plausible day with drifting clocks; a few items are pure noise.
    task automatic queue_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            queue_item(1'($urandom_range(1)), $urandom, 5'($urandom_range(31)),
                       6'($urandom_range(63)), 1'($urandom_range(1)), $urandom);
        end else begin
            if ($urandom_range(99) < 3) ms_now = $urandom;
            else ms_now = ms_now + $urandom_range(1, 300);
            if ($urandom_range(99) < 10) wall_minute = $urandom_range(1439);
            else wall_minute = (wall_minute + $urandom_range(0, 15)) % 1440;
            queue_item(pick < 36 ? dsws_pkg::CMD_PREVIEW : dsws_pkg::CMD_TICK, ms_now,
                       5'(wall_minute / 60), 6'(wall_minute % 60),
                       $urandom_range(99) >= 5,
                       $urandom_range(99) < 85 ? $urandom_range(0, 2000) : $urandom);
        end
    endtask

    // Called at a rising edge; returns at the edge where the write was taken.
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            dsws_pkg::REG_SLEEP_ENABLE: regs_model.sleep_enable       = data[0];
            dsws_pkg::REG_START_HOUR:   regs_model.start_hour         = data[4:0];
            dsws_pkg::REG_START_MINUTE: regs_model.start_minute       = data[5:0];
            dsws_pkg::REG_END_HOUR:     regs_model.end_hour           = data[4:0];
            dsws_pkg::REG_END_MINUTE:   regs_model.end_minute         = data[5:0];
            dsws_pkg::REG_SCREEN_AWAKE: regs_model.screen_level_awake = data;
            dsws_pkg::REG_LED_AWAKE:    regs_model.led_level_awake    = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [7:0] en, input logic [7:0] sh,
                                 input logic [7:0] sm, input logic [7:0] eh,
                                 input logic [7:0] em, input logic [7:0] scr,
                                 input logic [7:0] led);
        write_reg(dsws_pkg::REG_SLEEP_ENABLE, en);
        write_reg(dsws_pkg::REG_START_HOUR, sh);
        write_reg(dsws_pkg::REG_START_MINUTE, sm);
        write_reg(dsws_pkg::REG_END_HOUR, eh);
        write_reg(dsws_pkg::REG_END_MINUTE, em);
        write_reg(dsws_pkg::REG_SCREEN_AWAKE, scr);
        write_reg(dsws_pkg::REG_LED_AWAKE, led);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every item has been taken and every predicted result has arrived,
    // then lets the pipeline settle before the registers may be touched.
    task automatic drain();
        while (stim_queue.size() != 0 || i_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        regs_model = '{sleep_enable: 1'b0, start_hour: 5'd22, start_minute: 6'd0,
                       end_hour: 5'd7, end_minute: 6'd0, screen_level_awake: 8'd200,
                       led_level_awake: 8'd120};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With reset settings the window is disabled: a tick does nothing and a
        // preview is refused.
        queue_item(dsws_pkg::CMD_TICK, 32'd100, 5'd23, 6'd0, 1'b1, 32'd0);
        queue_item(dsws_pkg::CMD_PREVIEW, 32'd110, 5'd23, 6'd0, 1'b1, 32'd50);
        drain();

        apply_setting(8'h01, 8'd22, 8'd0, 8'd7, 8'd0, 8'd200, 8'd120);
        @(posedge i_clk);
        // Clock unknown.
        queue_item(dsws_pkg::CMD_TICK, 32'd200, 5'd0, 6'd0, 1'b0, 32'd0);
        // Awake, stays awake.
        queue_item(dsws_pkg::CMD_TICK, 32'd210, 5'd12, 6'd0, 1'b1, 32'd0);
        // Refused while awake.
        queue_item(dsws_pkg::CMD_PREVIEW, 32'd220, 5'd12, 6'd0, 1'b1, 32'd100);
        // Enters sleep.
        queue_item(dsws_pkg::CMD_TICK, 32'd230, 5'd23, 6'd30, 1'b1, 32'd0);
        queue_item(dsws_pkg::CMD_PREVIEW, 32'd1000, 5'd23, 6'd31, 1'b1, 32'd500);
        // One short of the deadline, then exactly at it.
        queue_item(dsws_pkg::CMD_TICK, 32'd1499, 5'd23, 6'd31, 1'b1, 32'd0);
        queue_item(dsws_pkg::CMD_TICK, 32'd1500, 5'd23, 6'd32, 1'b1, 32'd0);
        // Deadline that wraps past the top of the millisecond counter.
        queue_item(dsws_pkg::CMD_PREVIEW, 32'hFFFF_FF00, 5'd23, 6'd33, 1'b1, 32'h0000_0200);
        queue_item(dsws_pkg::CMD_TICK, 32'hFFFF_FFFF, 5'd23, 6'd33, 1'b0, 32'd0);
        queue_item(dsws_pkg::CMD_TICK, 32'h0000_0100, 5'd23, 6'd34, 1'b0, 32'd0);
        // Zero-length preview: the next tick both ends it and wakes the display.
        queue_item(dsws_pkg::CMD_PREVIEW, 32'd5, 5'd23, 6'd35, 1'b1, 32'd0);
        queue_item(dsws_pkg::CMD_TICK, 32'd5, 5'd8, 6'd0, 1'b1, 32'd0);
        // Early-morning side of the window.
        queue_item(dsws_pkg::CMD_TICK, 32'd6, 5'd6, 6'd59, 1'b1, 32'd0);
        queue_item(dsws_pkg::CMD_PREVIEW, 32'd10, 5'd6, 6'd59, 1'b1, 32'hFFFF_FFFF);
        queue_item(dsws_pkg::CMD_TICK, 32'd10, 5'd6, 6'd59, 1'b1, 32'd0);
        // End of the window wakes, start of the window sleeps.
        queue_item(dsws_pkg::CMD_TICK, 32'd11, 5'd7, 6'd0, 1'b1, 32'd0);
        queue_item(dsws_pkg::CMD_TICK, 32'd12, 5'd22, 6'd0, 1'b1, 32'd0);
        // Hour and minute beyond their usual range.
        queue_item(dsws_pkg::CMD_TICK, 32'd13, 5'd31, 6'd63, 1'b1, 32'd0);
        queue_item(dsws_pkg::CMD_TICK, 32'd14, 5'd0, 6'd0, 1'b1, 32'd0);
        // Deadline half the counter range away is still in the future.
        queue_item(dsws_pkg::CMD_PREVIEW, 32'h8000_0000, 5'd0, 6'd0, 1'b1, 32'h7FFF_FFFF);
        queue_item(dsws_pkg::CMD_TICK, 32'h7FFF_FFFF, 5'd0, 6'd1, 1'b1, 32'd0);
        drain();

        // Disabling the window while asleep with a preview running wakes on the next tick.
        write_reg(dsws_pkg::REG_SLEEP_ENABLE, 8'hFE);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        queue_item(dsws_pkg::CMD_TICK, 32'h7FFF_FFFF, 5'd0, 6'd2, 1'b1, 32'd0);
        queue_item(dsws_pkg::CMD_PREVIEW, 32'h8000_0001, 5'd0, 6'd2, 1'b1, 32'd10);
        drain();
        write_reg(REG_UNUSED, 8'hA5);
        cfg_valid <= 1'b0;
        @(posedge i_clk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: apply_setting(8'h01, 8'd22, 8'd0, 8'd7, 8'd0, 8'd200, 8'd120);
                1: apply_setting(8'hFF, 8'd8, 8'd30, 8'd17, 8'd45, 8'd255, 8'd255);
                // Equal start and end: the display never sleeps.
                2: apply_setting(8'h01, 8'd12, 8'd0, 8'd12, 8'd0, 8'd0, 8'd0);
                // Upper bits of the data are dropped, so the start lands on hour 31, minute 63.
                3: apply_setting(8'h01, 8'hFF, 8'hFF, 8'd5, 8'd0, 8'd1, 8'd254);
                4: apply_setting(8'h00, 8'd22, 8'd0, 8'd7, 8'd0, 8'd77, 8'd33);
                default: apply_setting(8'h01, 8'd20, 8'd15, 8'd6, 8'd45, 8'd128, 8'd64);
            endcase
            // Sender 18 % and receiver 74 % idle first, then the reverse, then no idling.
            if (phase < 2) begin
                src_idle_pct = 18;
                snk_idle_pct = 74;
            end else if (phase < 4) begin
                src_idle_pct = 74;
                snk_idle_pct = 18;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            @(posedge i_clk);
            repeat (PHASE_ITEMS) queue_random_item();
            if (phase == NUM_PHASES - 1) begin
                // The receiver stops for a long stretch while items keep arriving,
                // so both internal registers fill and the input is stalled.
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            drain();
        end

        $display("Checked %0d items over %0d random window settings and the directed cases.",
                 items_taken, NUM_PHASES);
        $display("Sleep entries %0d, wakes %0d, previews %0d, preview expiries %0d.",
                 n_sleeps, n_wakes, n_previews, n_expiries);
        if (errors == 0) begin
            $display("PASS display_sleep_window_scheduler_unit");
        end else begin
            $display("FAIL display_sleep_window_scheduler_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire
